/* sv/gcq_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and codes for the grid clearance query core.
// No dependencies; every other file refers to it by scoped names.
package gcq_pkg;

    // Map storage bounds
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = X_W + Y_W;
    localparam int DEPTH      = 1 << ADDR_W;

    // Field and datapath widths
    localparam int CMD_W   = 2;
    localparam int CRD_W   = 8;
    localparam int DIM_W   = 9;
    localparam int RAD_W   = 8;
    localparam int OFS_W   = 10;   // signed coordinate: centre plus offset
    localparam int SQ1_W   = 16;   // square of one offset
    localparam int SQ_W    = 17;   // squared distance
    localparam int ROOT_W  = 9;
    localparam int BIT_W   = $clog2(ROOT_W);

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_RADIUS = 2'd2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISC    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEAREST = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [CRD_W-1:0] center_x;
        logic [CRD_W-1:0] center_y;
        logic             cell_value;
    } t_item;

    typedef struct packed {
        logic              disc_clear;
        logic [ROOT_W-1:0] ring_radius;
        logic [SQ_W-1:0]   min_dist_sq;
    } t_result;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [RAD_W-1:0] radius;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic              wdata;
    } t_mem_req;

endpackage

/* sv/grid_clearance_query_core.sv */
`timescale 1ns / 1ps
// Top level of the grid clearance query core: configuration registers and clamping,
// the map memory, the sweep sequencer and the root unit. Uses gcq_pkg.
//
// One command is in work at a time: o_busy rises the cycle after start is taken and
// falls in the cycle the result strobe o_res_valid is high; the strobe lasts one cycle
// and cannot be held off. A cell write updates the map in the decode state, and the
// strobe is registered from that state. A disc check sweeps a (2r+1) x (2r+1) window
// at one map read per cycle on the single RAM port, ending early at the first cell
// inside the disc that is blocked or off the map. A nearest search sweeps a
// (2a-1) x (2a-1) window, a being the distance from the centre to the nearest map
// edge, then runs the bit-serial square root. The map is not cleared after reset; a
// cell must be written before any query covers it.
module grid_clearance_query_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  gcq_pkg::t_item                i_item,
    output logic                          o_res_valid,
    output gcq_pkg::t_result              o_res,
    input  logic                          i_cfg_we,
    input  logic [gcq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gcq_pkg::DIM_W-1:0]     i_cfg_data
);

    localparam logic [gcq_pkg::DIM_W-1:0] MaxW = gcq_pkg::DIM_W'(gcq_pkg::MAX_WIDTH);
    localparam logic [gcq_pkg::DIM_W-1:0] MaxH = gcq_pkg::DIM_W'(gcq_pkg::MAX_HEIGHT);

    logic [gcq_pkg::DIM_W-1:0] r_map_width;
    logic [gcq_pkg::DIM_W-1:0] r_map_height;
    logic [gcq_pkg::RAD_W-1:0] r_vehicle_radius;

    gcq_pkg::t_cfg              s_cfg;
    gcq_pkg::t_mem_req          s_mem_req;
    logic                       s_mem_rdata;
    logic                       s_sqrt_start;
    logic [gcq_pkg::SQ_W-1:0]   s_sqrt_value;
    logic                       s_sqrt_done;
    logic [gcq_pkg::ROOT_W-1:0] s_sqrt_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width      <= MaxW;
            r_map_height     <= MaxH;
            r_vehicle_radius <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gcq_pkg::CFG_MAP_WIDTH:      r_map_width      <= i_cfg_data;
                gcq_pkg::CFG_MAP_HEIGHT:     r_map_height     <= i_cfg_data;
                gcq_pkg::CFG_VEHICLE_RADIUS: r_vehicle_radius <= i_cfg_data[gcq_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize saturates to the storage bound
    always_comb begin
        if (r_map_width == '0) begin
            s_cfg.width = gcq_pkg::DIM_W'(1);
        end else if (r_map_width > MaxW) begin
            s_cfg.width = MaxW;
        end else begin
            s_cfg.width = r_map_width;
        end
        if (r_map_height == '0) begin
            s_cfg.height = gcq_pkg::DIM_W'(1);
        end else if (r_map_height > MaxH) begin
            s_cfg.height = MaxH;
        end else begin
            s_cfg.height = r_map_height;
        end
        s_cfg.radius = r_vehicle_radius;
    end

    gcq_map_ram u_map (
        .i_clk   (i_clk),
        .i_req   (s_mem_req),
        .o_rdata (s_mem_rdata)
    );

    gcq_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_sqrt_start),
        .i_value (s_sqrt_value),
        .o_done  (s_sqrt_done),
        .o_root  (s_sqrt_root)
    );

    gcq_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_item       (i_item),
        .i_cfg        (s_cfg),
        .o_busy       (o_busy),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res),
        .o_mem_req    (s_mem_req),
        .i_mem_rdata  (s_mem_rdata),
        .o_sqrt_start (s_sqrt_start),
        .o_sqrt_value (s_sqrt_value),
        .i_sqrt_done  (s_sqrt_done),
        .i_sqrt_root  (s_sqrt_root)
    );

endmodule

/* sv/gcq_map_ram.sv */
`timescale 1ns / 1ps
// One-bit occupancy map: single port, synchronous write, registered read.
// Depends on gcq_pkg for the depth and the request struct.
module gcq_map_ram (
    input  logic              i_clk,
    input  gcq_pkg::t_mem_req i_req,
    output logic              o_rdata
);

    logic r_mem [gcq_pkg::DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/gcq_isqrt.sv */
`timescale 1ns / 1ps
// Iterative ceiling square root: one result bit per cycle, then a round-up step.
// Depends on gcq_pkg for widths.
module gcq_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gcq_pkg::SQ_W-1:0]   i_value,
    output logic                       o_done,
    output logic [gcq_pkg::ROOT_W-1:0] o_root
);

    logic                       r_busy, n_busy;
    logic                       r_fix, n_fix;
    logic                       r_done, n_done;
    logic [gcq_pkg::BIT_W-1:0]  r_bit, n_bit;
    logic [gcq_pkg::ROOT_W-1:0] r_root, n_root;
    logic [gcq_pkg::SQ_W-1:0]   r_val, n_val;

    logic [gcq_pkg::ROOT_W-1:0]   s_trial;
    logic [gcq_pkg::ROOT_W-1:0]   s_op;
    logic [2*gcq_pkg::ROOT_W-1:0] s_sq;

    assign s_trial = r_root | (gcq_pkg::ROOT_W'(1) << r_bit);
    // one shared multiplier: trial square while iterating, root square when rounding
    assign s_op    = r_fix ? r_root : s_trial;
    assign s_sq    = (2*gcq_pkg::ROOT_W)'(s_op) * (2*gcq_pkg::ROOT_W)'(s_op);

    always_comb begin
        n_busy = r_busy;
        n_fix  = r_fix;
        n_done = 1'b0;
        n_bit  = r_bit;
        n_root = r_root;
        n_val  = r_val;
        if (i_start) begin
            n_busy = 1'b1;
            n_fix  = 1'b0;
            n_bit  = gcq_pkg::BIT_W'(gcq_pkg::ROOT_W - 1);
            n_root = '0;
            n_val  = i_value;
        end else if (r_busy && !r_fix) begin
            if (s_sq <= (2*gcq_pkg::ROOT_W)'(r_val)) begin
                n_root = s_trial;
            end
            if (r_bit == '0) begin
                n_fix = 1'b1;
            end else begin
                n_bit = r_bit - 1'b1;
            end
        end else if (r_busy) begin
            // round up when the floor root falls short
            if (s_sq < (2*gcq_pkg::ROOT_W)'(r_val)) begin
                n_root = r_root + 1'b1;
            end
            n_busy = 1'b0;
            n_fix  = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fix  <= n_fix;
            r_done <= n_done;
        end
        r_bit  <= n_bit;
        r_root <= n_root;
        r_val  <= n_val;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* sv/gcq_scan.sv */
`timescale 1ns / 1ps
// Command sequencer: decodes an item, writes the map or sweeps a square window
// of map cells one read per cycle, and forms the result. Uses gcq_pkg.
module gcq_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  gcq_pkg::t_item             i_item,
    input  gcq_pkg::t_cfg              i_cfg,
    output logic                       o_busy,
    output logic                       o_res_valid,
    output gcq_pkg::t_result           o_res,
    output gcq_pkg::t_mem_req          o_mem_req,
    input  logic                       i_mem_rdata,
    output logic                       o_sqrt_start,
    output logic [gcq_pkg::SQ_W-1:0]   o_sqrt_value,
    input  logic                       i_sqrt_done,
    input  logic [gcq_pkg::ROOT_W-1:0] i_sqrt_root
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_ROOT   = 3'd5;

    localparam int OW = gcq_pkg::OFS_W;
    localparam int SW = gcq_pkg::SQ1_W + 2;   // signed width for square updates

    logic [2:0]                        r_state, n_state;
    logic [gcq_pkg::CMD_W-1:0]         r_cmd, n_cmd;
    logic [gcq_pkg::CRD_W-1:0]         r_cx, n_cx;
    logic [gcq_pkg::CRD_W-1:0]         r_cy, n_cy;
    logic                              r_val, n_val;
    logic [gcq_pkg::DIM_W-1:0]         r_a, n_a;
    logic [gcq_pkg::RAD_W-1:0]         r_k, n_k;
    logic [gcq_pkg::SQ1_W-1:0]         r_k2, n_k2;
    logic [gcq_pkg::SQ_W-1:0]          r_lim, n_lim;
    logic signed [OW-1:0]              r_dx, n_dx;
    logic signed [OW-1:0]              r_dy, n_dy;
    logic [gcq_pkg::SQ1_W-1:0]         r_dx2, n_dx2;
    logic [gcq_pkg::SQ1_W-1:0]         r_dy2, n_dy2;
    logic                              r_p_valid, n_p_valid;
    logic                              r_p_use, n_p_use;
    logic                              r_p_out, n_p_out;
    logic [gcq_pkg::SQ_W-1:0]          r_p_d2, n_p_d2;
    logic                              r_res_valid, n_res_valid;
    gcq_pkg::t_result                  r_res, n_res;
    logic                              r_sqrt_start, n_sqrt_start;

    logic                         s_inside;
    logic [gcq_pkg::DIM_W-1:0]    s_cx9, s_cy9;
    logic [gcq_pkg::DIM_W-1:0]    s_e1, s_e2, s_e3, s_e4, s_m12, s_m34, s_edge;
    logic signed [OW-1:0]         s_kpos;
    logic signed [OW-1:0]         s_x, s_y;
    logic                         s_out;
    logic [gcq_pkg::SQ_W-1:0]     s_d2;
    logic signed [SW-1:0]         s_dx_step, s_dy_step;
    logic [2*gcq_pkg::DIM_W-1:0]  s_a_sq;
    logic                         s_hit;
    logic [gcq_pkg::ADDR_W-1:0]   s_scan_addr, s_ctr_addr;

    assign s_cx9    = {1'b0, r_cx};
    assign s_cy9    = {1'b0, r_cy};
    assign s_inside = (s_cx9 < i_cfg.width) && (s_cy9 < i_cfg.height);

    // distance from the centre to the first out-of-map cell along each axis
    assign s_e1   = s_cx9 + 1'b1;
    assign s_e2   = i_cfg.width - s_cx9;
    assign s_e3   = s_cy9 + 1'b1;
    assign s_e4   = i_cfg.height - s_cy9;
    assign s_m12  = (s_e1 < s_e2) ? s_e1 : s_e2;
    assign s_m34  = (s_e3 < s_e4) ? s_e3 : s_e4;
    assign s_edge = (s_m12 < s_m34) ? s_m12 : s_m34;

    assign s_kpos = signed'({2'b00, r_k});
    assign s_x    = signed'({2'b00, r_cx}) + r_dx;
    assign s_y    = signed'({2'b00, r_cy}) + r_dy;
    assign s_out  = s_x[OW-1] || s_y[OW-1]
                  || (s_x[gcq_pkg::DIM_W-1:0] >= i_cfg.width)
                  || (s_y[gcq_pkg::DIM_W-1:0] >= i_cfg.height);
    assign s_d2   = gcq_pkg::SQ_W'(r_dx2) + gcq_pkg::SQ_W'(r_dy2);

    // (d+1)^2 = d^2 + 2d + 1
    assign s_dx_step = {{(SW-OW-1){r_dx[OW-1]}}, r_dx, 1'b1};
    assign s_dy_step = {{(SW-OW-1){r_dy[OW-1]}}, r_dy, 1'b1};

    assign s_a_sq = (2*gcq_pkg::DIM_W)'(r_a) * (2*gcq_pkg::DIM_W)'(r_a);

    // previous cycle's cell: memory data is valid now
    assign s_hit = r_p_valid && r_p_use && (r_p_out || i_mem_rdata);

    assign s_scan_addr = {s_y[gcq_pkg::Y_W-1:0], s_x[gcq_pkg::X_W-1:0]};
    assign s_ctr_addr  = {r_cy[gcq_pkg::Y_W-1:0], r_cx[gcq_pkg::X_W-1:0]};

    // Items run one at a time, so a write has retired before any later read.
    always_comb begin
        o_mem_req.we    = (r_state == S_DECODE) && (r_cmd == gcq_pkg::CMD_WRITE) && s_inside;
        o_mem_req.wdata = r_val;
        o_mem_req.addr  = (r_state == S_SCAN) ? s_scan_addr : s_ctr_addr;
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_val        = r_val;
        n_a          = r_a;
        n_k          = r_k;
        n_k2         = r_k2;
        n_lim        = r_lim;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_dx2        = r_dx2;
        n_dy2        = r_dy2;
        n_p_valid    = 1'b0;
        n_p_use      = r_p_use;
        n_p_out      = r_p_out;
        n_p_d2       = r_p_d2;
        n_res_valid  = 1'b0;
        n_res        = r_res;
        n_sqrt_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_item.command;
                    n_cx    = i_item.center_x;
                    n_cy    = i_item.center_y;
                    n_val   = i_item.cell_value;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_cmd)
                    gcq_pkg::CMD_DISC: begin
                        n_a     = {1'b0, i_cfg.radius};
                        n_k     = i_cfg.radius;
                        n_state = S_SETUP;
                    end
                    gcq_pkg::CMD_NEAREST: begin
                        if (s_inside) begin
                            // no obstacle nearer than the map edge lies outside this window
                            n_a     = s_edge;
                            n_k     = gcq_pkg::RAD_W'(s_edge - 1'b1);
                            n_state = S_SETUP;
                        end else begin
                            n_lim        = '0;
                            n_sqrt_start = 1'b1;
                            n_state      = S_ROOT;
                        end
                    end
                    default: begin
                        // write, and the unused code: all-zero result
                        n_res       = '0;
                        n_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                endcase
            end
            S_SETUP: begin
                n_lim   = gcq_pkg::SQ_W'(s_a_sq);
                n_k2    = gcq_pkg::SQ1_W'(r_k) * gcq_pkg::SQ1_W'(r_k);
                n_dx2   = n_k2;
                n_dy2   = n_k2;
                n_dx    = -s_kpos;
                n_dy    = -s_kpos;
                n_state = S_SCAN;
            end
            S_SCAN, S_DRAIN: begin
                if (r_cmd == gcq_pkg::CMD_DISC && s_hit) begin
                    // drop the cell in flight and report blocked
                    n_res            = '0;
                    n_res.disc_clear = 1'b0;
                    n_res_valid      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    if (s_hit && (r_p_d2 < r_lim)) begin
                        n_lim = r_p_d2;
                    end
                    if (r_state == S_SCAN) begin
                        n_p_valid = 1'b1;
                        n_p_use   = (r_cmd == gcq_pkg::CMD_DISC) ? (s_d2 <= r_lim) : 1'b1;
                        n_p_out   = s_out;
                        n_p_d2    = s_d2;
                        if (r_dx == s_kpos) begin
                            n_dx  = -s_kpos;
                            n_dx2 = r_k2;
                            n_dy  = r_dy + 1'b1;
                            n_dy2 = gcq_pkg::SQ1_W'(signed'({2'b00, r_dy2}) + s_dy_step);
                            if (r_dy == s_kpos) begin
                                n_state = S_DRAIN;
                            end
                        end else begin
                            n_dx  = r_dx + 1'b1;
                            n_dx2 = gcq_pkg::SQ1_W'(signed'({2'b00, r_dx2}) + s_dx_step);
                        end
                    end else if (r_cmd == gcq_pkg::CMD_DISC) begin
                        n_res            = '0;
                        n_res.disc_clear = 1'b1;
                        n_res_valid      = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_sqrt_start = 1'b1;
                        n_state      = S_ROOT;
                    end
                end
            end
            S_ROOT: begin
                if (i_sqrt_done) begin
                    n_res             = '0;
                    n_res.ring_radius = i_sqrt_root;
                    n_res.min_dist_sq = r_lim;
                    n_res_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_p_valid    <= 1'b0;
            r_res_valid  <= 1'b0;
            r_sqrt_start <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_p_valid    <= n_p_valid;
            r_res_valid  <= n_res_valid;
            r_sqrt_start <= n_sqrt_start;
        end
        r_cmd   <= n_cmd;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_val   <= n_val;
        r_a     <= n_a;
        r_k     <= n_k;
        r_k2    <= n_k2;
        r_lim   <= n_lim;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_dx2   <= n_dx2;
        r_dy2   <= n_dy2;
        r_p_use <= n_p_use;
        r_p_out <= n_p_out;
        r_p_d2  <= n_p_d2;
        r_res   <= n_res;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_res_valid  = r_res_valid;
    assign o_res        = r_res;
    assign o_sqrt_start = r_sqrt_start;
    assign o_sqrt_value = r_lim;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not raise busy");

    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("cell in flight outside a sweep");

    a_write_only_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |-> (r_state == S_DECODE && r_cmd == gcq_pkg::CMD_WRITE))
        else $error("map write outside a write command");

    a_nearest_window_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cmd == gcq_pkg::CMD_NEAREST) |-> !s_out)
        else $error("nearest search window leaves the map");

    a_root_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sqrt_done |-> (r_state == S_ROOT))
        else $error("root result with no search waiting");
`endif

endmodule
